FILE: rtl/core/rlmp_pkg.sv
// Package for the RGB lamp mode PWM controller: state and config structs,
// register indexes, mode codes and the fixed colour table. No dependencies.
package rlmp_pkg;

  localparam int LEVEL_W  = 8;
  localparam int MODE_W   = 4;
  localparam int STEP_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [MODE_W-1:0]  MODE_OFF     = 4'd0;
  localparam logic [MODE_W-1:0]  MODE_WHITE_R = 4'd1;
  localparam logic [MODE_W-1:0]  MODE_LAST_FIXED = 4'd7;
  localparam logic [MODE_W-1:0]  MODE_RAINBOW = 4'd8;
  localparam logic [LEVEL_W-1:0] PWM_LAST     = 8'd254;
  localparam logic [LEVEL_W-1:0] ORANGE_GREEN = 8'h25;

  localparam logic [LEVEL_W-1:0] DEBOUNCE_MIN_RST  = 8'd8;
  localparam logic [LEVEL_W-1:0] HOLD_CAP_RST      = 8'd200;
  localparam logic [LEVEL_W-1:0] SLEEP_TIMEOUT_RST = 8'd200;
  localparam logic [LEVEL_W-1:0] FADE_HIGH_RST     = 8'd250;
  localparam logic [LEVEL_W-1:0] FADE_MID_RST      = 8'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MIN  = 3'd0,
    CFG_HOLD_CAP      = 3'd1,
    CFG_SLEEP_TIMEOUT = 3'd2,
    CFG_FADE_HIGH     = 3'd3,
    CFG_FADE_MID      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] debounce_min;
    logic [LEVEL_W-1:0] hold_cap;
    logic [LEVEL_W-1:0] sleep_timeout;
    logic [LEVEL_W-1:0] fade_high;
    logic [LEVEL_W-1:0] fade_mid;
  } lamp_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               leds_enabled;
    logic [LEVEL_W-1:0] level_red;
    logic [LEVEL_W-1:0] level_green;
    logic [LEVEL_W-1:0] level_blue;
    logic [LEVEL_W-1:0] pwm_count;
    logic [LEVEL_W-1:0] hold_count;
    logic [LEVEL_W-1:0] idle_count;
    logic [STEP_W-1:0]  fade_step;
    logic [LEVEL_W-1:0] target_red;
    logic [LEVEL_W-1:0] target_green;
    logic [LEVEL_W-1:0] target_blue;
  } lamp_state_t;

  typedef struct packed {
    logic              red_on;
    logic              green_on;
    logic              blue_on;
    logic              sleep_enter;
    logic [MODE_W-1:0] mode_now;
  } lamp_result_t;

  // {red, green, blue} for the fixed colour modes
  function automatic logic [3*LEVEL_W-1:0] fixed_colour(input logic [STEP_W-1:0] idx);
    logic [3*LEVEL_W-1:0] c;
    case (idx)
      3'd1:    c = {8'hFF, 8'h00, 8'h00};
      3'd2:    c = {8'hFF, ORANGE_GREEN, 8'h00};
      3'd3:    c = {8'hFF, 8'hFF, 8'h00};
      3'd4:    c = {8'h00, 8'hFF, 8'h00};
      3'd5:    c = {8'h00, 8'hFF, 8'hFF};
      3'd6:    c = {8'h00, 8'h00, 8'hFF};
      3'd7:    c = {8'hFF, 8'h00, 8'hFF};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/rlmp_step.sv
// Next-state and result logic for one request (pwm slot or tick).
// Purely combinational; depends on rlmp_pkg.
module rlmp_step (
  input  rlmp_pkg::lamp_state_t  cur,
  input  rlmp_pkg::lamp_cfg_t    cfg,
  input  logic                   kind,
  input  logic                   key_pressed,
  output rlmp_pkg::lamp_state_t  nxt,
  output rlmp_pkg::lamp_result_t res
);
  import rlmp_pkg::*;

  function automatic logic [LEVEL_W-1:0] step_toward(input logic [LEVEL_W-1:0] v,
                                                     input logic [LEVEL_W-1:0] t);
    logic [LEVEL_W-1:0] r;
    if (v > t) r = v - 8'd1;
    else if (v < t) r = v + 8'd1;
    else r = v;
    return r;
  endfunction

  logic [LEVEL_W:0]     hold_inc;
  logic [LEVEL_W:0]     idle_inc;
  logic                 click;
  logic [MODE_W-1:0]    mode_a;
  logic [LEVEL_W-1:0]   lr_a, lg_a, lb_a;
  logic [STEP_W-1:0]    fs_a;
  logic [3*LEVEL_W-1:0] colour;
  logic [LEVEL_W-1:0]   tr, tg, tb;
  logic [LEVEL_W-1:0]   fr, fg, fb;

  always_comb begin
    nxt      = cur;
    res      = '0;
    hold_inc = {1'b0, cur.hold_count} + 9'd1;
    idle_inc = '0;
    click    = 1'b0;
    mode_a   = cur.mode;
    lr_a     = cur.level_red;
    lg_a     = cur.level_green;
    lb_a     = cur.level_blue;
    fs_a     = cur.fade_step;
    colour   = fixed_colour(cur.mode[STEP_W-1:0]);
    tr = cur.target_red;
    tg = cur.target_green;
    tb = cur.target_blue;
    fr = '0;
    fg = '0;
    fb = '0;

    if (!kind) begin
      if (cur.leds_enabled) begin
        res.red_on    = cur.level_red   > cur.pwm_count;
        res.green_on  = cur.level_green > cur.pwm_count;
        res.blue_on   = cur.level_blue  > cur.pwm_count;
        nxt.pwm_count = (cur.pwm_count >= PWM_LAST) ? '0 : cur.pwm_count + 8'd1;
      end
    end else begin
      // button
      if (key_pressed) begin
        nxt.hold_count = (hold_inc >= {1'b0, cfg.hold_cap}) ? cfg.hold_cap
                                                            : hold_inc[LEVEL_W-1:0];
      end else begin
        click          = cur.hold_count >= cfg.debounce_min;
        nxt.hold_count = '0;
      end

      if (click) begin
        mode_a = (cur.mode >= MODE_RAINBOW) ? MODE_OFF : cur.mode + 4'd1;
        if (mode_a == MODE_RAINBOW) begin
          fs_a = 3'd1;
          lr_a = '0;
          lg_a = '0;
          lb_a = '0;
        end
      end else if (cur.mode > MODE_RAINBOW) begin
        mode_a = MODE_OFF;
      end
      nxt.mode      = mode_a;
      nxt.fade_step = fs_a;
      colour        = fixed_colour(mode_a[STEP_W-1:0]);

      // rainbow targets
      case (fs_a)
        3'd1:    begin tr = cfg.fade_high; tg = '0;           tb = '0;            end
        3'd2:    begin tr = cfg.fade_high; tg = cfg.fade_mid; tb = '0;            end
        3'd3:    begin tr = cfg.fade_high; tg = cfg.fade_high; tb = '0;           end
        3'd4:    begin tr = '0;            tg = cfg.fade_high; tb = '0;           end
        3'd5:    begin tr = '0;            tg = cfg.fade_high; tb = cfg.fade_high; end
        3'd6:    begin tr = '0;            tg = '0;            tb = cfg.fade_high; end
        3'd7:    begin tr = cfg.fade_mid;  tg = '0;            tb = cfg.fade_high; end
        default: ;
      endcase
      fr = step_toward(lr_a, tr);
      fg = step_toward(lg_a, tg);
      fb = step_toward(lb_a, tb);

      if (mode_a == MODE_OFF) begin
        nxt.leds_enabled = 1'b0;
        nxt.level_red    = lr_a;
        nxt.level_green  = lg_a;
        nxt.level_blue   = lb_a;
      end else if (mode_a <= MODE_LAST_FIXED) begin
        if (mode_a == MODE_WHITE_R) nxt.leds_enabled = 1'b1;
        nxt.level_red   = colour[3*LEVEL_W-1:2*LEVEL_W];
        nxt.level_green = colour[2*LEVEL_W-1:LEVEL_W];
        nxt.level_blue  = colour[LEVEL_W-1:0];
      end else begin
        nxt.target_red   = tr;
        nxt.target_green = tg;
        nxt.target_blue  = tb;
        nxt.level_red    = fr;
        nxt.level_green  = fg;
        nxt.level_blue   = fb;
        if (fr == tr && fg == tg && fb == tb) begin
          nxt.fade_step = (fs_a == 3'd7) ? 3'd1 : fs_a + 3'd1;
        end
      end

      // idle timeout in off mode
      if (nxt.hold_count == '0 && mode_a == MODE_OFF) begin
        idle_inc = {1'b0, cur.idle_count} + 9'd1;
        if (idle_inc > {1'b0, cfg.sleep_timeout}) begin
          nxt.idle_count  = '0;
          res.sleep_enter = 1'b1;
        end else begin
          nxt.idle_count = idle_inc[LEVEL_W-1:0];
        end
      end else begin
        nxt.idle_count = '0;
      end
    end
    res.mode_now = nxt.mode;
  end

endmodule

FILE: rtl/core/rgb_lamp_mode_pwm_controller_core.sv
// RGB lamp mode PWM controller, top level: config registers, lamp state,
// output register. Depends on rlmp_pkg and rlmp_step.
//
//  channel | ports                          | dir | handshake
//  in      | in_kind, in_key_pressed        | in  | in_valid / in_ready
//  out     | out_*_on, out_sleep_enter, ... | out | out_valid / out_ready
//  cfg     | cfg_index, cfg_data            | in  | cfg_valid / cfg_ready
//
// One request per cycle while in_ready is high; the result appears in the
// cycle after acceptance. The result register is the only stage: in_ready
// is high whenever it is empty or being drained. cfg_ready is always high.
// Synchronous reset restores register defaults and clears all lamp state.
module rgb_lamp_mode_pwm_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic                             in_key_pressed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_red_on,
  output logic                             out_green_on,
  output logic                             out_blue_on,
  output logic                             out_sleep_enter,
  output logic [rlmp_pkg::MODE_W-1:0]      out_mode_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlmp_pkg::LEVEL_W-1:0]     cfg_data
);
  import rlmp_pkg::*;

  lamp_cfg_t    cfg_r;
  lamp_state_t  st_r, st_nxt;
  lamp_result_t res_nxt, res_r;
  logic         out_valid_r;
  logic         in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_min  <= DEBOUNCE_MIN_RST;
      cfg_r.hold_cap      <= HOLD_CAP_RST;
      cfg_r.sleep_timeout <= SLEEP_TIMEOUT_RST;
      cfg_r.fade_high     <= FADE_HIGH_RST;
      cfg_r.fade_mid      <= FADE_MID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MIN:  cfg_r.debounce_min  <= cfg_data;
        CFG_HOLD_CAP:      cfg_r.hold_cap      <= cfg_data;
        CFG_SLEEP_TIMEOUT: cfg_r.sleep_timeout <= cfg_data;
        CFG_FADE_HIGH:     cfg_r.fade_high     <= cfg_data;
        CFG_FADE_MID:      cfg_r.fade_mid      <= cfg_data;
        default: ;
      endcase
    end
  end

  rlmp_step u_step (
    .cur         (st_r),
    .cfg         (cfg_r),
    .kind        (in_kind),
    .key_pressed (in_key_pressed),
    .nxt         (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) st_r <= st_nxt;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_red_on      = res_r.red_on;
  assign out_green_on    = res_r.green_on;
  assign out_blue_on     = res_r.blue_on;
  assign out_sleep_enter = res_r.sleep_enter;
  assign out_mode_now    = res_r.mode_now;

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode <= MODE_RAINBOW) else $error("mode out of range");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_OFF) |-> !st_r.leds_enabled) else $error("leds on in off mode");

  a_pwm_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pwm_count <= PWM_LAST) else $error("pwm counter past wrap");

  a_sleep_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.sleep_enter) |->
      (res_r.mode_now == MODE_OFF && !res_r.red_on && !res_r.green_on && !res_r.blue_on))
    else $error("sleep result with lamp lit or mode set");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r) else $error("input stalled with empty output");

endmodule

FILE: tb/sv/rgb_lamp_mode_pwm_controller_core_checker.sv
// Result checker for the RGB lamp controller: follows request, result and
// register-write channels, predicts every result and compares it field by field.
// Depends on rlmp_pkg.
module rgb_lamp_mode_pwm_controller_core_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_kind,
  input  logic                           in_key_pressed,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_red_on,
  input  logic                           out_green_on,
  input  logic                           out_blue_on,
  input  logic                           out_sleep_enter,
  input  logic [rlmp_pkg::MODE_W-1:0]    out_mode_now,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rlmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlmp_pkg::LEVEL_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output logic [rlmp_pkg::MODE_W-1:0]    mode_predicted
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlmp_pkg::*;

  localparam int PRINT_CAP = 100;
  localparam logic [STEP_W-1:0] FADE_FIRST = 3'd1;
  localparam logic [STEP_W-1:0] FADE_LAST  = 3'd7;

  // {red, green, blue}, highest mode first
  localparam logic [MODE_LAST_FIXED:MODE_WHITE_R][3*LEVEL_W-1:0] FIXED_RGB = {
    {8'hFF, 8'h00, 8'hFF},
    {8'h00, 8'h00, 8'hFF},
    {8'h00, 8'hFF, 8'hFF},
    {8'h00, 8'hFF, 8'h00},
    {8'hFF, 8'hFF, 8'h00},
    {8'hFF, ORANGE_GREEN, 8'h00},
    {8'hFF, 8'h00, 8'h00}
  };

  lamp_cfg_t    regs;
  lamp_state_t  lamp;
  lamp_result_t pending_results[$];

  initial mismatches = 0;

  function automatic logic [LEVEL_W-1:0] nudge(input logic [LEVEL_W-1:0] v,
                                               input logic [LEVEL_W-1:0] t);
    if (v > t) return v - 8'd1;
    if (v < t) return v + 8'd1;
    return v;
  endfunction

  function automatic lamp_result_t advance_lamp(input logic is_tick, input logic pressed);
    lamp_result_t r;
    logic click;
    logic [LEVEL_W:0] n;
    logic [LEVEL_W-1:0] h, m;
    logic [FADE_LAST:FADE_FIRST][3*LEVEL_W-1:0] goal;
    r = '0;
    if (!is_tick) begin
      if (lamp.leds_enabled) begin
        r.red_on   = lamp.level_red > lamp.pwm_count;
        r.green_on = lamp.level_green > lamp.pwm_count;
        r.blue_on  = lamp.level_blue > lamp.pwm_count;
        lamp.pwm_count = (lamp.pwm_count >= PWM_LAST) ? '0 : lamp.pwm_count + 8'd1;
      end
    end else begin
      click = 1'b0;
      if (pressed) begin
        n = {1'b0, lamp.hold_count} + 9'd1;
        if (n >= {1'b0, regs.hold_cap}) n = {1'b0, regs.hold_cap};
        lamp.hold_count = n[LEVEL_W-1:0];
      end else begin
        click = lamp.hold_count >= regs.debounce_min;
        lamp.hold_count = '0;
      end
      if (click) begin
        lamp.mode = (lamp.mode >= MODE_RAINBOW) ? MODE_OFF : lamp.mode + 4'd1;
        if (lamp.mode == MODE_RAINBOW) begin
          lamp.fade_step = FADE_FIRST;
          lamp.level_red = '0;
          lamp.level_green = '0;
          lamp.level_blue = '0;
        end
      end
      if (lamp.mode > MODE_RAINBOW) lamp.mode = MODE_OFF;
      if (lamp.mode == MODE_OFF) begin
        lamp.leds_enabled = 1'b0;
      end else if (lamp.mode <= MODE_LAST_FIXED) begin
        if (lamp.mode == MODE_WHITE_R) lamp.leds_enabled = 1'b1;
        {lamp.level_red, lamp.level_green, lamp.level_blue} = FIXED_RGB[lamp.mode];
      end else begin
        h = regs.fade_high;
        m = regs.fade_mid;
        goal = {{m, 8'h00, h}, {8'h00, 8'h00, h}, {8'h00, h, h}, {8'h00, h, 8'h00},
                {h, h, 8'h00}, {h, m, 8'h00}, {h, 8'h00, 8'h00}};
        // step zero keeps whatever targets are already set
        if (lamp.fade_step != '0)
          {lamp.target_red, lamp.target_green, lamp.target_blue} = goal[lamp.fade_step];
        lamp.level_red   = nudge(lamp.level_red, lamp.target_red);
        lamp.level_green = nudge(lamp.level_green, lamp.target_green);
        lamp.level_blue  = nudge(lamp.level_blue, lamp.target_blue);
        if (lamp.level_red == lamp.target_red && lamp.level_green == lamp.target_green &&
            lamp.level_blue == lamp.target_blue)
          lamp.fade_step = (lamp.fade_step == FADE_LAST) ? FADE_FIRST : lamp.fade_step + 3'd1;
      end
      // idle count compared at 9 bits so a timeout of 255 still fires
      if (lamp.hold_count == '0 && lamp.mode == MODE_OFF) begin
        n = {1'b0, lamp.idle_count} + 9'd1;
        if (n > {1'b0, regs.sleep_timeout}) begin
          lamp.idle_count = '0;
          lamp.mode = MODE_OFF;
          r.sleep_enter = 1'b1;
        end else begin
          lamp.idle_count = n[LEVEL_W-1:0];
        end
      end else begin
        lamp.idle_count = '0;
      end
    end
    r.mode_now = lamp.mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lamp_result_t want, got;
    if (!rst_n) begin
      regs = {DEBOUNCE_MIN_RST, HOLD_CAP_RST, SLEEP_TIMEOUT_RST, FADE_HIGH_RST, FADE_MID_RST};
      lamp = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_red_on, out_green_on, out_blue_on, out_sleep_enter, out_mode_now};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending, mode_now", got.mode_now, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.red_on != want.red_on)
            report_mismatch("red_on", got.red_on, want.red_on);
          if (got.green_on != want.green_on)
            report_mismatch("green_on", got.green_on, want.green_on);
          if (got.blue_on != want.blue_on)
            report_mismatch("blue_on", got.blue_on, want.blue_on);
          if (got.sleep_enter != want.sleep_enter)
            report_mismatch("sleep_enter", got.sleep_enter, want.sleep_enter);
          if (got.mode_now != want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(advance_lamp(in_kind, in_key_pressed));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE_MIN:  regs.debounce_min = cfg_data;
          CFG_HOLD_CAP:      regs.hold_cap = cfg_data;
          CFG_SLEEP_TIMEOUT: regs.sleep_timeout = cfg_data;
          CFG_FADE_HIGH:     regs.fade_high = cfg_data;
          CFG_FADE_MID:      regs.fade_mid = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
    mode_predicted <= lamp.mode;
  end

endmodule

FILE: tb/sv/rgb_lamp_mode_pwm_controller_core_tb.sv
// Testbench top for the RGB lamp controller: clock, reset, request and
// register-write stimulus, result-side stalls and the verdict.
// Depends on rlmp_pkg, rgb_lamp_mode_pwm_controller_core and its checker.
module rgb_lamp_mode_pwm_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlmp_pkg::*;

  localparam logic KIND_PWM  = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int IDLE_MAX = 14;
  localparam int DRAIN_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_PWM;
  logic in_key_pressed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_red_on, out_green_on, out_blue_on, out_sleep_enter;
  logic [MODE_W-1:0] out_mode_now;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE_MIN;
  logic [LEVEL_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  logic [MODE_W-1:0] mode_predicted;
  int sent = 0;
  int cfg_writes = 0;
  int settings = 0;
  int tx_calm = 0;

  rgb_lamp_mode_pwm_controller_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_key_pressed(in_key_pressed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red_on(out_red_on), .out_green_on(out_green_on), .out_blue_on(out_blue_on),
    .out_sleep_enter(out_sleep_enter), .out_mode_now(out_mode_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rgb_lamp_mode_pwm_controller_core_checker lamp_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_key_pressed(in_key_pressed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red_on(out_red_on), .out_green_on(out_green_on), .out_blue_on(out_blue_on),
    .out_sleep_enter(out_sleep_enter), .out_mode_now(out_mode_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .mode_predicted(mode_predicted)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("run did not finish in time, %0d results outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls with occasional stretches of none
  initial begin
    int stall;
    int rx_calm;
    rx_calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_calm > 0) begin
        rx_calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, IDLE_MAX);
        if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(8, 40);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_request(input logic kind, input logic key);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, IDLE_MAX);
      if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key_pressed <= key;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (outstanding != 0 && n < DRAIN_LIMIT);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [LEVEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic apply_settings(input lamp_cfg_t s);
    wait_drained();
    write_register(CFG_DEBOUNCE_MIN, s.debounce_min);
    write_register(CFG_HOLD_CAP, s.hold_cap);
    write_register(CFG_SLEEP_TIMEOUT, s.sleep_timeout);
    write_register(CFG_FADE_HIGH, s.fade_high);
    write_register(CFG_FADE_MID, s.fade_mid);
    write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                   LEVEL_W'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // held ticks then a release; pwm slots may fall in between
  task automatic click(input int presses);
    repeat (presses) begin
      if ($urandom_range(0, 3) == 0) send_request(KIND_PWM, 1'($urandom_range(0, 1)));
      send_request(KIND_TICK, 1'b1);
    end
    send_request(KIND_TICK, 1'b0);
  endtask

  task automatic run_random(input int budget, input int press_max);
    int start;
    int pick;
    start = sent;
    while (sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        click($urandom_range(0, press_max));
      else if (pick < 75)
        repeat ($urandom_range(1, 12)) send_request(KIND_PWM, 1'($urandom_range(0, 1)));
      else if (pick < 88)
        repeat ($urandom_range(1, 8)) send_request(KIND_TICK, 1'b0);
      else
        repeat ($urandom_range(1, 4))
          send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    lamp_cfg_t s;
    int laps;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // fields: {debounce_min, hold_cap, sleep_timeout, fade_high, fade_mid}
    apply_settings({8'd1, 8'd2, 8'd3, 8'd2, 8'd1});
    send_request(KIND_PWM, 1'b1);
    repeat (4) send_request(KIND_TICK, 1'b0);
    repeat (3) send_request(KIND_TICK, 1'b1);
    send_request(KIND_TICK, 1'b0);
    repeat (2) send_request(KIND_PWM, 1'b0);
    repeat (2) begin
      send_request(KIND_TICK, 1'b1);
      send_request(KIND_TICK, 1'b0);
    end
    // zero debounce: every release clicks, runs up into the rainbow
    apply_settings({8'd0, 8'd2, 8'd3, 8'd2, 8'd1});
    repeat (5) send_request(KIND_TICK, 1'b0);
    repeat (3) send_request(KIND_TICK, 1'b1);
    send_request(KIND_PWM, 1'b0);

    apply_settings({8'd2, 8'd4, 8'd6, 8'd3, 8'd1});
    run_random(80, 6);
    apply_settings({8'd1, 8'd1, 8'd1, 8'd0, 8'd0});
    run_random(50, 3);
    // debounce above cap: no clicks possible
    apply_settings({8'd255, 8'd5, 8'd10, 8'd40, 8'd20});
    run_random(30, 8);

    // full-range timeout: walk back to off, then idle long enough to sleep
    apply_settings({8'd2, 8'd255, 8'd255, 8'd255, 8'd255});
    wait_drained();
    laps = (mode_predicted == MODE_OFF) ? 0 : int'(MODE_RAINBOW) + 1 - int'(mode_predicted);
    repeat (laps) click(2);
    repeat (258) send_request(KIND_TICK, 1'b0);
    run_random(30, 4);

    repeat (3) begin
      s.debounce_min  = LEVEL_W'($urandom_range(1, 4));
      s.hold_cap      = LEVEL_W'($urandom_range(1, 10));
      s.sleep_timeout = LEVEL_W'($urandom_range(1, 12));
      s.fade_high     = LEVEL_W'($urandom_range(0, 12));
      s.fade_mid      = LEVEL_W'($urandom_range(0, 255));
      apply_settings(s);
      run_random(50, 12);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d requests under %0d register settings, %0d register writes", sent,
             settings, cfg_writes);
    $display("covered dark pwm slots, hold saturation, clicks through all modes, rainbow fade,");
    $display("debounce above cap and idle timeouts from 1 to 255");
    if (outstanding != 0) $display("%0d results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
